// ===== sv/wav_header_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// wav_header_parser_core_macros.svh
// Assertion macros for the WAV header parser. They compile to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_CORE_MACROS_SVH
`define WAV_HEADER_PARSER_CORE_MACROS_SVH

`ifndef SYNTH
// Implication checked on every clock edge outside reset
`define WHP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");
// Condition that must never be seen outside reset
`define WHP_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed: lbl");
`else
`define WHP_ASSERT_IMPL(lbl, ante, cons)
`define WHP_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== sv/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg
// Types, status codes and the tag table shared by the WAV header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package whp_pkg;

	// offset of the last header byte
	localparam logic [5:0] HDR_LAST = 6'd43;

	// result status codes
	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_RIFF     = 4'd1,
		ST_WAVE     = 4'd2,
		ST_FMT      = 4'd3,
		ST_DATA     = 4'd4,
		ST_FMTSIZE  = 4'd5,
		ST_FORMAT   = 4'd6,
		ST_CHANNELS = 4'd7,
		ST_BYTERATE = 4'd8,
		ST_BITS     = 4'd9,
		ST_ALIGN    = 4'd10
	} status_t;

	// one classified header, passed from front to back
	typedef struct packed {
		logic        tag_err;
		status_t     err;
		logic [31:0] file_size;
		logic [31:0] fmt_size;
		logic [15:0] format_tag;
		logic [15:0] channels;
		logic [31:0] samp_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] bits_per_sample;
		logic [31:0] data_size;
	} job_t;

	// expected tag byte at an offset
	typedef struct packed {
		logic    hit;
		status_t err;
		logic [7:0] want;
	} tag_t;

	function automatic tag_t tag_at(input logic [5:0] off);
		tag_t t;
		t = '{hit: 1'b0, err: ST_OK, want: 8'h00};
		case (off)
			6'd0:  t = '{hit: 1'b1, err: ST_RIFF, want: 8'h52};
			6'd1:  t = '{hit: 1'b1, err: ST_RIFF, want: 8'h49};
			6'd2:  t = '{hit: 1'b1, err: ST_RIFF, want: 8'h46};
			6'd3:  t = '{hit: 1'b1, err: ST_RIFF, want: 8'h46};
			6'd8:  t = '{hit: 1'b1, err: ST_WAVE, want: 8'h57};
			6'd9:  t = '{hit: 1'b1, err: ST_WAVE, want: 8'h41};
			6'd10: t = '{hit: 1'b1, err: ST_WAVE, want: 8'h56};
			6'd11: t = '{hit: 1'b1, err: ST_WAVE, want: 8'h45};
			6'd12: t = '{hit: 1'b1, err: ST_FMT,  want: 8'h66};
			6'd13: t = '{hit: 1'b1, err: ST_FMT,  want: 8'h6d};
			6'd14: t = '{hit: 1'b1, err: ST_FMT,  want: 8'h74};
			6'd15: t = '{hit: 1'b1, err: ST_FMT,  want: 8'h20};
			6'd36: t = '{hit: 1'b1, err: ST_DATA, want: 8'h64};
			6'd37: t = '{hit: 1'b1, err: ST_DATA, want: 8'h61};
			6'd38: t = '{hit: 1'b1, err: ST_DATA, want: 8'h74};
			6'd39: t = '{hit: 1'b1, err: ST_DATA, want: 8'h61};
			default: t = '{hit: 1'b0, err: ST_OK, want: 8'h00};
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== sv/whp_front.sv =====
// ----------------------------------------------------------------------------
// whp_front
// Takes header bytes, compares tag bytes and assembles the little-endian
// fields; pushes one job per finished or rejected header.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_front import whp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] header_byte,
	output logic            push,
	output job_t            push_job,
	input  wire logic       q_ready
);

	logic [5:0]  off_q;
	logic [31:0] riff_size_q;
	logic [31:0] fmt_size_q;
	logic [15:0] format_tag_q;
	logic [15:0] channels_q;
	logic [31:0] rate_q;
	logic [31:0] byte_rate_q;
	logic [31:0] align_bits_q;
	logic [23:0] data_size_q;

	tag_t tag;
	logic accept;
	logic mismatch;
	logic last;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign tag      = tag_at(off_q);
	assign mismatch = tag.hit && (header_byte != tag.want);
	assign last     = (off_q == HDR_LAST);
	assign push     = accept && (mismatch || last);

	// build the job record for a rejected or completed header
	always_comb begin
		push_job = '0;
		if (mismatch) begin
			push_job.tag_err = 1'b1;
			push_job.err     = tag.err;
		end else begin
			push_job.tag_err         = 1'b0;
			push_job.err             = ST_OK;
			push_job.file_size       = riff_size_q;
			push_job.fmt_size        = fmt_size_q;
			push_job.format_tag      = format_tag_q;
			push_job.channels        = channels_q;
			push_job.samp_rate       = rate_q;
			push_job.byte_rate       = byte_rate_q;
			push_job.block_align     = align_bits_q[15:0];
			push_job.bits_per_sample = align_bits_q[31:16];
			push_job.data_size       = {header_byte, data_size_q};
		end
	end

	// advance the offset; restart after a mismatch or the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (accept) begin
			if (mismatch || last) begin
				off_q <= '0;
			end else begin
				off_q <= off_q + 6'd1;
			end
		end
	end

	// shift field bytes into place; every byte is rewritten per header
	always_ff @(posedge clk) begin
		if (accept) begin
			case (off_q) inside
				[6'd4:6'd7]:   riff_size_q[off_q[1:0]*8 +: 8]  <= header_byte;
				[6'd16:6'd19]: fmt_size_q[off_q[1:0]*8 +: 8]   <= header_byte;
				[6'd20:6'd21]: format_tag_q[off_q[0]*8 +: 8]   <= header_byte;
				[6'd22:6'd23]: channels_q[off_q[0]*8 +: 8]     <= header_byte;
				[6'd24:6'd27]: rate_q[off_q[1:0]*8 +: 8]       <= header_byte;
				[6'd28:6'd31]: byte_rate_q[off_q[1:0]*8 +: 8]  <= header_byte;
				[6'd32:6'd35]: align_bits_q[off_q[1:0]*8 +: 8] <= header_byte;
				[6'd40:6'd42]: data_size_q[off_q[1:0]*8 +: 8]  <= header_byte;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/whp_queue.sv =====
// ----------------------------------------------------------------------------
// whp_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_queue import whp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      q_ready,
	output logic      q_valid,
	output job_t      q_job,
	input  wire logic pop
);

	job_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign q_ready = (count_q != 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_job   = mem_q[rd_ptr_q];

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// store the pushed job
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

// ===== sv/whp_back.sv =====
// ----------------------------------------------------------------------------
// whp_back
// Validates queued headers in two stages: rate times align product, then
// the ordered field checks into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_back import whp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  job_t        q_job,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output status_t     out_status,
	output job_t        out_job
);

	logic        v_s1;
	job_t        job_s1;
	logic [31:0] prod_s1;
	logic        out_v_q;
	status_t     status_q;
	job_t        out_q;

	logic        out_en;
	logic        s1_en;
	logic [47:0] prod_full;
	logic [15:0] want_align;
	status_t     st;

	assign out_en     = !out_v_q || out_ready;
	assign s1_en      = !v_s1 || out_en;
	assign pop        = q_valid && s1_en;
	assign prod_full  = q_job.samp_rate * q_job.block_align;
	assign out_valid  = out_v_q;
	assign out_status = status_q;
	assign out_job    = out_q;

	// expected align once bits and channels have passed their checks
	assign want_align = (job_s1.bits_per_sample == 16'd16) ?
		{job_s1.channels[14:0], 1'b0} : job_s1.channels;

	// first failing check gives the status
	always_comb begin
		if (job_s1.tag_err)                           st = job_s1.err;
		else if (job_s1.fmt_size != 32'd16)           st = ST_FMTSIZE;
		else if (job_s1.format_tag != 16'd1)          st = ST_FORMAT;
		else if (job_s1.channels != 16'd1 && job_s1.channels != 16'd2)
			st = ST_CHANNELS;
		else if (job_s1.byte_rate != prod_s1)         st = ST_BYTERATE;
		else if (job_s1.bits_per_sample != 16'd8 && job_s1.bits_per_sample != 16'd16)
			st = ST_BITS;
		else if (job_s1.block_align != want_align)    st = ST_ALIGN;
		else                                          st = ST_OK;
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en)  v_s1    <= q_valid;
			if (out_en) out_v_q <= v_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (s1_en) begin
			job_s1  <= q_job;
			prod_s1 <= prod_full[31:0];
		end
		if (out_en) begin
			out_q    <= job_s1;
			status_q <= st;
		end
	end

endmodule

`default_nettype wire

// ===== sv/wav_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// wav_header_parser_core
// Canonical 44-byte PCM WAV header parser with valid/ready channels.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle, sustained, as long as the result side
// keeps up. A wrong tag byte gives an error result at once with all fields
// zero; after the last byte the fmt size, format, channels, byte rate, bits
// and block align are checked in that order and one result is given. Parsing
// restarts at offset 0 after every result. Jobs pass through a two-entry
// queue into a two-stage check pipeline (the rate-times-align multiplier has
// its own stage): a job passes the queue, the product stage and then the
// output register. While the output is stalled up to four results are held;
// once the queue is full the input stalls too.
`default_nettype none

`include "wav_header_parser_core_macros.svh"

module wav_header_parser_core import whp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  header_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [31:0]      file_size,
	output logic [31:0]      samp_rate,
	output logic [31:0]      byte_rate,
	output logic [15:0]      channels,
	output logic [15:0]      block_align,
	output logic [15:0]      bits_per_sample,
	output logic [31:0]      data_size
);

	logic    push;
	job_t    push_job;
	logic    q_ready;
	logic    q_valid;
	job_t    q_job;
	logic    pop;
	status_t out_status;
	job_t    out_job;

	whp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.header_byte (header_byte),
		.push        (push),
		.push_job    (push_job),
		.q_ready     (q_ready)
	);

	whp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.q_ready  (q_ready),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.pop      (pop)
	);

	whp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_job      (q_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_status (out_status),
		.out_job    (out_job)
	);

	// drive the result ports
	assign status          = out_status;
	assign file_size       = out_job.file_size;
	assign samp_rate       = out_job.samp_rate;
	assign byte_rate       = out_job.byte_rate;
	assign channels        = out_job.channels;
	assign block_align     = out_job.block_align;
	assign bits_per_sample = out_job.bits_per_sample;
	assign data_size       = out_job.data_size;

	// checks on the queue and result contents
	`WHP_ASSERT_NEVER(a_push_full, push && !q_ready)
	`WHP_ASSERT_IMPL(a_ok_chan, out_valid && out_status == ST_OK, channels == 16'd1 || channels == 16'd2)
	`WHP_ASSERT_IMPL(a_tag_zero, out_valid && out_job.tag_err, (file_size == '0) && (data_size == '0))

endmodule

`default_nettype wire

// ===== bench/tb_wav_header_parser_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_wav_header_parser_core
// Self-checking bench for the WAV header parser. Header bytes go in with
// random gaps on both sides. The bench parses the same byte stream itself
// and queues the result each header should give. Every field of each
// result word is compared with the oldest queued one.
// ---------------------------------------------------------------------------
module tb_wav_header_parser_core import whp_pkg::*; ();

	localparam int HDR_BYTES    = 44;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 16;
	localparam int RANDOM_BYTES = 200;

	localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;
	localparam logic [15:0] FMT_PCM       = 16'd1;
	localparam logic [31:0] TAG_RIFF      = "RIFF";
	localparam logic [31:0] TAG_WAVE      = "WAVE";
	localparam logic [31:0] TAG_FMT       = "fmt ";
	localparam logic [31:0] TAG_DATA      = "data";

	typedef struct {
		status_t     st;
		logic [31:0] file_size, samp_rate, byte_rate;
		logic [15:0] channels, block_align, bits_per_sample;
		logic [31:0] data_size;
	} hdr_result_t;

	typedef struct {
		logic [31:0] file_size, fmt_len, samp_rate, byte_rate, data_size;
		logic [15:0] fmt, channels, block_align, bits_per_sample;
	} hdr_fields_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  header_byte;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  status;
	logic [31:0] file_size;
	logic [31:0] samp_rate;
	logic [31:0] byte_rate;
	logic [15:0] channels;
	logic [15:0] block_align;
	logic [15:0] bits_per_sample;
	logic [31:0] data_size;

	// parser copy held by the bench
	int          hdr_pos;
	logic [7:0]  hdr_buf [0:HDR_BYTES-1];
	hdr_result_t pending_results [$];

	int fail_count;
	int bytes_sent;
	int results_made;
	int hold_reqs;
	bit tx_burst;
	bit rx_burst;

	wav_header_parser_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.header_byte     (header_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.file_size       (file_size),
		.samp_rate       (samp_rate),
		.byte_rate       (byte_rate),
		.channels        (channels),
		.block_align     (block_align),
		.bits_per_sample (bits_per_sample),
		.data_size       (data_size)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Tag byte expected at an offset, and the status a mismatch there gives
	function automatic bit tag_want(input int off, output status_t code,
			output logic [7:0] want);
		logic [31:0] tag;
		tag  = 32'h0;
		code = ST_OK;
		want = 8'h00;
		if (off < 4) begin
			tag  = TAG_RIFF;
			code = ST_RIFF;
		end else if (off >= 8 && off < 12) begin
			tag  = TAG_WAVE;
			code = ST_WAVE;
		end else if (off >= 12 && off < 16) begin
			tag  = TAG_FMT;
			code = ST_FMT;
		end else if (off >= 36 && off < 40) begin
			tag  = TAG_DATA;
			code = ST_DATA;
		end else begin
			return 1'b0;
		end
		want = tag[31 - 8 * (off % 4) -: 8];
		return 1'b1;
	endfunction

	function automatic logic [31:0] le_word(input int base);
		return {hdr_buf[base+3], hdr_buf[base+2], hdr_buf[base+1], hdr_buf[base]};
	endfunction

	// Advance the bench's parse by one accepted byte; queue any result it gives
	task automatic parse_byte(input logic [7:0] b);
		status_t     code;
		logic [7:0]  want;
		bit          is_tag;
		hdr_result_t r;
		logic [31:0] fmt_len, fmt_chan, align_bits, prod;
		is_tag = tag_want(hdr_pos, code, want);
		if (is_tag && b != want) begin
			r = '{code, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0};
			pending_results.push_back(r);
			results_made++;
			hdr_pos = 0;
		end else begin
			hdr_buf[hdr_pos] = b;
			if (hdr_pos < HDR_BYTES - 1) begin
				hdr_pos++;
			end else begin
				// header complete: assemble fields, first failing check wins
				fmt_len           = le_word(16);
				fmt_chan          = le_word(20);
				align_bits        = le_word(32);
				r.file_size       = le_word(4);
				r.samp_rate       = le_word(24);
				r.byte_rate       = le_word(28);
				r.channels        = fmt_chan[31:16];
				r.block_align     = align_bits[15:0];
				r.bits_per_sample = align_bits[31:16];
				r.data_size       = le_word(40);
				prod = r.samp_rate * {16'd0, r.block_align};
				if (fmt_len != FMT_CHUNK_LEN)
					r.st = ST_FMTSIZE;
				else if (fmt_chan[15:0] != FMT_PCM)
					r.st = ST_FORMAT;
				else if (r.channels != 16'd1 && r.channels != 16'd2)
					r.st = ST_CHANNELS;
				else if (r.byte_rate != prod)
					r.st = ST_BYTERATE;
				else if (r.bits_per_sample != 16'd8 && r.bits_per_sample != 16'd16)
					r.st = ST_BITS;
				else if (r.block_align != r.bits_per_sample / 16'd8 * r.channels)
					r.st = ST_ALIGN;
				else
					r.st = ST_OK;
				pending_results.push_back(r);
				results_made++;
				hdr_pos = 0;
			end
		end
	endtask

	// Offer one byte, hold it until taken, then draw the gap before the next
	task automatic push_header_byte(input logic [7:0] b);
		int gap;
		in_valid    <= 1'b1;
		header_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		parse_byte(b);
		bytes_sent++;
		@(negedge clk);
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every queued result has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Serialise a header image, byte i
	function automatic logic [7:0] hdr_image_byte(input hdr_fields_t f, input int i);
		status_t     code;
		logic [7:0]  want;
		logic [31:0] w;
		if (tag_want(i, code, want))
			return want;
		case (i / 4)
			1:       w = f.file_size;
			4:       w = f.fmt_len;
			5:       w = {f.channels, f.fmt};
			6:       w = f.samp_rate;
			7:       w = f.byte_rate;
			8:       w = {f.bits_per_sample, f.block_align};
			default: w = f.data_size;
		endcase
		return w[8 * (i % 4) +: 8];
	endfunction

	// Send a header, optionally with one byte replaced; stop after a broken tag
	task automatic send_header(input hdr_fields_t f, input int tamper_pos,
			input logic [7:0] tamper_val);
		logic [7:0] b;
		logic [7:0] want;
		status_t    code;
		bit         stop;
		int         i;
		stop = 1'b0;
		for (i = 0; i < HDR_BYTES && !stop; i++) begin
			b = hdr_image_byte(f, i);
			if (i == tamper_pos) begin
				b    = tamper_val;
				stop = tag_want(i, code, want);
				stop = stop && (b != want);
			end
			push_header_byte(b);
		end
	endtask

	function automatic hdr_fields_t good_fields(input logic [15:0] chans,
			input logic [15:0] bits, input logic [31:0] rate);
		hdr_fields_t f;
		f.file_size       = $urandom;
		f.fmt_len         = FMT_CHUNK_LEN;
		f.fmt             = FMT_PCM;
		f.channels        = chans;
		f.bits_per_sample = bits;
		f.block_align     = bits / 16'd8 * chans;
		f.samp_rate       = rate;
		f.byte_rate       = rate * {16'd0, f.block_align};
		f.data_size       = $urandom;
		return f;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result word with the oldest queued expectation
	always @(posedge clk) begin : result_check
		hdr_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("status: expected no word, got 0x%0h", status);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", {28'd0, exp_r.st}, {28'd0, status});
				check_field("file_size", exp_r.file_size, file_size);
				check_field("samp_rate", exp_r.samp_rate, samp_rate);
				check_field("byte_rate", exp_r.byte_rate, byte_rate);
				check_field("channels", {16'd0, exp_r.channels}, {16'd0, channels});
				check_field("block_align", {16'd0, exp_r.block_align},
					{16'd0, block_align});
				check_field("bits_per_sample", {16'd0, exp_r.bits_per_sample},
					{16'd0, bits_per_sample});
				check_field("data_size", exp_r.data_size, data_size);
			end
		end
	end

	// Result side: random stalls per word, plus a long hold when asked
	initial begin : result_sink
		int wait_left;
		int hold_left;
		int holds_seen;
		bit took;
		wait_left  = 0;
		hold_left  = 0;
		holds_seen = 0;
		took       = 1'b0;
		out_ready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_seen != hold_reqs) begin
				hold_left  = HOLD_CYCLES;
				holds_seen = hold_reqs;
			end
			if (took) begin
				wait_left = rx_burst ? 0 : $urandom_range(0, 11);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
			took = out_valid && out_ready;
		end
	end

	// Well-formed headers with extreme field values
	task automatic test_good_headers();
		hdr_fields_t f;
		f = good_fields(16'd1, 16'd8, 32'd8000);
		f.file_size = 32'h0;
		f.data_size = 32'h0;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd2, 16'd16, 32'd44100);
		f.file_size = 32'hFFFF_FFFF;
		f.data_size = 32'hFFFF_FFFF;
		send_header(f, -1, 8'h00);
		// byte rate wraps modulo 2^32
		send_header(good_fields(16'd2, 16'd16, 32'hFFFF_FFFF), -1, 8'h00);
		send_header(good_fields(16'd1, 16'd16, 32'd0), -1, 8'h00);
		send_header(good_fields(16'd2, 16'd8, 32'd48000), -1, 8'h00);
		wait_drain();
	endtask

	// Break the first and last byte of each tag
	task automatic test_tag_errors();
		int tag_start [4];
		int k;
		tag_start = '{0, 8, 12, 36};
		for (k = 0; k < 4; k++) begin
			send_header(good_fields(16'd1, 16'd8, 32'd22050), tag_start[k], 8'h00);
			send_header(good_fields(16'd2, 16'd16, 32'd96000), tag_start[k] + 3, 8'hFF);
		end
		wait_drain();
	endtask

	// Headers that fail each validation check, high bytes of 16-bit fields included
	task automatic test_field_checks();
		hdr_fields_t f;
		f = good_fields(16'd2, 16'd16, 32'd44100);
		f.fmt_len = 32'd18;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd2, 16'd16, 32'd44100);
		f.fmt_len = 32'h0001_0010;
		f.fmt     = 16'd3;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd1, 16'd8, 32'd11025);
		f.fmt = 16'h0101;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd1, 16'd8, 32'd11025);
		f.channels = 16'd0;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd1, 16'd8, 32'd11025);
		f.channels = 16'h0101;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd2, 16'd16, 32'd32000);
		f.channels = 16'hFFFF;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd2, 16'd16, 32'd32000);
		f.byte_rate = f.byte_rate + 32'd1;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd1, 16'd8, 32'd16000);
		f.bits_per_sample = 16'd24;
		f.block_align     = 16'd3;
		f.byte_rate       = f.samp_rate * 32'd3;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd1, 16'd8, 32'd16000);
		f.bits_per_sample = 16'hFFFF;
		send_header(f, -1, 8'h00);
		f = good_fields(16'd2, 16'd16, 32'd48000);
		f.block_align = 16'd2;
		f.byte_rate   = f.samp_rate * 32'd2;
		send_header(f, -1, 8'h00);
		wait_drain();
	endtask

	// Hold the result side off while bytes keep coming, so the input stalls
	task automatic test_backpressure();
		logic [7:0] b;
		hold_reqs++;
		tx_burst = 1'b1;
		repeat (24) begin
			b = 8'($urandom);
			if (b == TAG_RIFF[31:24])
				b = ~b;
			push_header_byte(b);
		end
		tx_burst = 1'b0;
		wait_drain();
	endtask

	// Well-formed headers with random content, plus broken headers and noise
	task automatic test_random();
		hdr_fields_t f;
		int          kind;
		int          tamper_pos;
		int          t;
		int          bytes0;
		logic [7:0]  tamper_val;
		bytes0 = bytes_sent;
		while (bytes_sent - bytes0 < RANDOM_BYTES) begin
			tx_burst   = ($urandom_range(0, 3) == 0);
			rx_burst   = ($urandom_range(0, 3) == 0);
			kind       = $urandom_range(0, 15);
			tamper_pos = -1;
			tamper_val = 8'h00;
			f = good_fields(16'($urandom_range(1, 2)),
				($urandom_range(0, 1) != 0) ? 16'd16 : 16'd8, $urandom);
			case (kind)
				0: f.fmt_len = $urandom;
				1: f.fmt = 16'($urandom);
				2: f.channels = 16'($urandom);
				3: f.byte_rate = f.byte_rate ^ (32'd1 << $urandom_range(0, 31));
				4: f.bits_per_sample = 16'($urandom);
				5: f.block_align = 16'($urandom);
				6: begin
					f.fmt_len         = $urandom;
					f.fmt             = 16'($urandom);
					f.channels        = 16'($urandom);
					f.samp_rate       = $urandom;
					f.byte_rate       = $urandom;
					f.block_align     = 16'($urandom);
					f.bits_per_sample = 16'($urandom);
				end
				7: begin
					// land on one of the sixteen tag bytes
					t          = $urandom_range(0, 15);
					tamper_pos = (t < 4) ? t : (t < 12) ? t + 4 : t + 24;
					tamper_val = 8'($urandom);
				end
				8: begin
					tamper_pos = $urandom_range(0, HDR_BYTES - 1);
					tamper_val = 8'($urandom);
				end
				default: ;
			endcase
			if (kind == 9) begin
				// raw noise, then random bytes until the parse is back at offset 0
				repeat ($urandom_range(1, 6)) push_header_byte(8'($urandom));
				while (hdr_pos != 0) push_header_byte(8'($urandom));
			end else begin
				send_header(f, tamper_pos, tamper_val);
			end
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		wait_drain();
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		header_byte  = 8'h00;
		hdr_pos      = 0;
		fail_count   = 0;
		bytes_sent   = 0;
		results_made = 0;
		hold_reqs    = 0;
		tx_burst     = 1'b0;
		rx_burst     = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_good_headers();
		test_tag_errors();
		test_field_checks();
		test_backpressure();
		test_random();

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
